FILE: src/lca_pkg.sv
// Shared types and constants for the life cellular automaton block.
// No dependencies; imported by lca_cell and life_cellular_automaton_top.
`timescale 1ns / 1ps
`default_nettype none

package lca_pkg;

    // Default board edge length and the number of rows a dump carries at most
    localparam int GRID_SIZE_DEF = 16;
    localparam int MAX_OUT_ROWS  = 16;

    // B3/S23 neighbour counts
    localparam int BIRTH_COUNT   = 3;
    localparam int SURVIVE_COUNT = 2;

    // Command codes
    localparam logic [1:0] MODE_SET  = 2'd0;
    localparam logic [1:0] MODE_SHOW = 2'd1;
    localparam logic [1:0] MODE_STEP = 2'd2;
    localparam logic [1:0] MODE_NOP  = 2'd3;

    typedef struct packed {
        logic [1:0] mode;
        logic [3:0] row;
        logic [3:0] col;
    } cmd_item_t;

    typedef struct packed {
        logic [3:0]  row_index;
        logic [15:0] row_cells;
        logic        last_row;
    } res_item_t;

    // Per-cycle control broadcast to every cell of the chain
    typedef struct packed {
        logic shift;
        logic step;
    } cell_ctrl_t;

endpackage

`default_nettype wire

FILE: src/lca_cell.sv
// One cell of the row chain: holds one board row, applies the B3/S23 rule
// from its neighbour rows and hands its row on when the chain rotates. Uses lca_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lca_cell #(
    parameter int WIDTH = lca_pkg::GRID_SIZE_DEF
) (
    input  wire                     clk,
    input  wire                     rst_n,
    input  wire lca_pkg::cell_ctrl_t ctrl,
    input  wire  [WIDTH-1:0]        set_mask,
    input  wire  [WIDTH-1:0]        above,
    input  wire  [WIDTH-1:0]        below,
    input  wire  [WIDTH-1:0]        feed,
    output logic [WIDTH-1:0]        row
);
    import lca_pkg::*;

    logic [WIDTH-1:0] row_reg;
    logic [WIDTH-1:0] row_next;
    logic [WIDTH-1:0] gen_row;
    logic [WIDTH+1:0] above_pad;
    logic [WIDTH+1:0] mid_pad;
    logic [WIDTH+1:0] below_pad;

    assign above_pad = {1'b0, above, 1'b0};
    assign mid_pad   = {1'b0, row_reg, 1'b0};
    assign below_pad = {1'b0, below, 1'b0};

    // Count the eight neighbours of each column; columns are independent
    always_comb
    begin
        logic [3:0] cnt;
        for (int j = 0; j < WIDTH; j++)
        begin
            cnt = 4'(above_pad[j]) + 4'(above_pad[j+1]) + 4'(above_pad[j+2])
                + 4'(mid_pad[j])                        + 4'(mid_pad[j+2])
                + 4'(below_pad[j]) + 4'(below_pad[j+1]) + 4'(below_pad[j+2]);
            gen_row[j] = (cnt == 4'(BIRTH_COUNT))
                      || ((cnt == 4'(SURVIVE_COUNT)) && row_reg[j]);
        end
    end

    always_comb
    begin
        priority if (ctrl.step)
            row_next = gen_row;
        else if (ctrl.shift)
            row_next = feed;
        else
            row_next = row_reg | set_mask;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            row_reg <= '0;
        else
            row_reg <= row_next;
    end

    assign row = row_reg;

endmodule

`default_nettype wire

FILE: src/life_cellular_automaton_top.sv
// Game of Life (B3/S23) board of GRID_SIZE x GRID_SIZE cells with hard edges.
// A set is written into its row as it is taken. The first row of a show or step passes the
//   sequencer state register, then the result register. A show or step holds the command
//   side while the chain rotates once past the result register, one row per cycle unless stalled.
// Reset (rst_n, asynchronous, active low) clears the whole board to dead at once.
// Depends on lca_pkg and lca_cell.
`timescale 1ns / 1ps
`default_nettype none

module life_cellular_automaton_top #(
    parameter int GRID_SIZE = lca_pkg::GRID_SIZE_DEF
) (
    input  wire                   clk,
    input  wire                   rst_n,
    input  wire                   cmd_valid,
    output logic                  cmd_stall,
    input  wire lca_pkg::cmd_item_t cmd,
    output logic                  res_valid,
    input  wire                   res_stall,
    output lca_pkg::res_item_t    res
);
    import lca_pkg::*;

    localparam int CW       = $clog2(GRID_SIZE);
    localparam int OUT_ROWS = (GRID_SIZE < MAX_OUT_ROWS) ? GRID_SIZE : MAX_OUT_ROWS;

    typedef enum logic {
        ST_IDLE,
        ST_DUMP
    } state_t;

    state_t         state_reg;
    logic [CW-1:0]  count_reg;
    logic           res_valid_reg;
    res_item_t      res_reg;

    logic           cmd_acc;
    logic           slot_free;
    logic           emit;
    logic           advance;
    cell_ctrl_t     ctrl;

    // Rows of the chain; cell 0 is the head that feeds the result register
    logic [GRID_SIZE-1:0] rows [GRID_SIZE];
    logic [GRID_SIZE-1:0] col_mask;
    logic [GRID_SIZE+15:0] head_ext;
    logic [CW+3:0]        count_ext;

    assign cmd_acc   = cmd_valid && !cmd_stall;
    assign cmd_stall = (state_reg != ST_IDLE);
    assign slot_free = !res_valid_reg || !res_stall;

    // Rows past the sixteenth still rotate so the board comes back in place,
    // but they drop out of the dump and need no free result slot
    assign emit    = ({1'b0, count_reg} < (CW+1)'(OUT_ROWS));
    assign advance = (state_reg == ST_DUMP) && (!emit || slot_free);

    assign ctrl.step  = cmd_acc && (cmd.mode == MODE_STEP);
    assign ctrl.shift = advance;

    // Column decode for set; columns beyond the board simply match no bit
    always_comb
    begin
        for (int j = 0; j < GRID_SIZE; j++)
            col_mask[j] = (int'(cmd.col) == j);
    end

    genvar gi;
    generate
        for (gi = 0; gi < GRID_SIZE; gi++)
        begin : g_chain
            logic [GRID_SIZE-1:0] set_mask;
            logic [GRID_SIZE-1:0] above;
            logic [GRID_SIZE-1:0] below;
            logic [GRID_SIZE-1:0] feed;

            assign set_mask = (cmd_acc && (cmd.mode == MODE_SET) && (int'(cmd.row) == gi))
                              ? col_mask : '0;
            // Hard edges: outside rows read as dead; rotation feeds the head row into the tail
            if (gi == 0)
            begin : g_top
                assign above = '0;
            end
            else
            begin : g_inner_a
                assign above = rows[gi-1];
            end
            if (gi == GRID_SIZE-1)
            begin : g_bottom
                assign below = '0;
                assign feed  = rows[0];
            end
            else
            begin : g_inner_b
                assign below = rows[gi+1];
                assign feed  = rows[gi+1];
            end

            lca_cell #(
                .WIDTH (GRID_SIZE)
            ) u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .ctrl     (ctrl),
                .set_mask (set_mask),
                .above    (above),
                .below    (below),
                .feed     (feed),
                .row      (rows[gi])
            );
        end
    endgenerate

    // Widen then trim: only columns 0..15 and the low four bits of the row number travel
    assign head_ext  = {16'b0, rows[0]};
    assign count_ext = {4'b0, count_reg};

    // Sequencer: idle until a show or step, then rotate the chain once
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                ST_IDLE:
                begin
                    count_reg <= '0;
                    if (cmd_acc && ((cmd.mode == MODE_SHOW) || (cmd.mode == MODE_STEP)))
                        state_reg <= ST_DUMP;
                end
                ST_DUMP:
                begin
                    if (advance)
                    begin
                        count_reg <= count_reg + 1'b1;
                        if (count_reg == CW'(GRID_SIZE-1))
                            state_reg <= ST_IDLE;
                    end
                end
                default:
                    state_reg <= ST_IDLE;
            endcase

            // Result register: load a row when emitting, drop the item once taken
            if (advance && emit)
                res_valid_reg <= 1'b1;
            else if (!res_stall)
                res_valid_reg <= 1'b0;
        end
    end

    // Payload holds while stalled; it needs no reset
    always_ff @(posedge clk)
    begin
        if (advance && emit)
        begin
            res_reg.row_index <= count_ext[3:0];
            res_reg.row_cells <= head_ext[15:0];
            res_reg.last_row  <= ({1'b0, count_reg} == (CW+1)'(OUT_ROWS-1));
        end
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    // A show or step must lock out the command side on the next cycle
    a_dump_locks: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_acc && ((cmd.mode == MODE_SHOW) || (cmd.mode == MODE_STEP)) |=> cmd_stall)
        else $error("command side open after show/step item");

    // A set finishes in the cycle it is taken
    a_set_single: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_acc && (cmd.mode == MODE_SET) |=> !cmd_stall)
        else $error("set item held the command side");

    // The final row of a dump carries the last row number
    a_last_index: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res.last_row |-> (res.row_index == 4'(OUT_ROWS-1)))
        else $error("last_row flagged on wrong row");

    // No dump row is emitted while the sequencer is idle
    a_emit_in_dump: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |=> !$rose(res_valid) || $past(state_reg == ST_DUMP))
        else $error("result appeared outside a dump");

endmodule

`default_nettype wire
